// ===== hw/rtl/crlf_pkg.sv =====
`timescale 1ns / 1ps

package crlf_pkg;

	// Input commands
	typedef enum logic [1:0] {
		CMD_DATA    = 2'd0,
		CMD_END     = 2'd1,
		CMD_RESTART = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_LINE = 2'd1,
		KIND_OVFL = 2'd2,
		KIND_END  = 2'd3
	} kind_t;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	// Build-time line buffer limit; the payload limit never exceeds 255.
	localparam int MAX_CAPACITY = 256;
	localparam int CAP_W        = 9;
	localparam logic [CAP_W-1:0] CAP_LIMIT =
		CAP_W'((MAX_CAPACITY < 256) ? MAX_CAPACITY : 256);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// Result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [7:0]  line_length;
		logic [31:0] line_number;
		logic        last_of_item;
	} result_t;

endpackage

// ===== hw/rtl/crlf_line_splitter_unit.sv =====
`timescale 1ns / 1ps

// CRLF line splitter: frames a byte stream into lines.
//
// Item channel (item_valid / item_stall): one transaction carries a command
// (data byte, end of input, restart) and a data byte. Result channel
// (result_valid / result_stall): one transaction per result, with kind,
// out_byte, line_length, line_number and last_of_item.
// Config channel (cfg_valid / cfg_ready / cfg_data): writes line_capacity;
// always ready, write only while the block is idle.
//
// An item's results enter the 4-entry result queue when the item is taken
// and leave it in order. Throughput: one item per cycle while item_stall
// is low; each item yields zero, one or two results, and the result port
// drains one per cycle while result_stall is low, so an item with two
// results takes two result transactions. The line state updates on each
// taken item; item side stalls while fewer than two queue slots are free.
//
// Reset: line state and counters cleared, capacity set to 256, queue empty.
// A stalled receiver fills the queue, which then stalls the item side; no
// result is dropped or repeated.
module crlf_line_splitter_unit (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [7:0]  out_byte,
	output logic [7:0]  line_length,
	output logic [31:0] line_number,
	output logic        last_of_item,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [crlf_pkg::CAP_W-1:0] cfg_data
);
	import crlf_pkg::*;

	// Line state
	logic [CAP_W-1:0] cap_q;
	logic [7:0]       byte_count_q;
	logic             holding_cr_q;
	logic             discarding_q;
	logic             ended_q;
	logic [31:0]      line_count_q;

	// Result queue
	result_t             rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_CNT_W-1:0] rq_count_q;

	logic item_take;
	logic result_take;

	// Next-state and results of the current item
	logic [7:0]  byte_count_d;
	logic        holding_cr_d;
	logic        discarding_d;
	logic        ended_d;
	logic [31:0] line_count_d;
	result_t     res0;
	result_t     res1;
	logic [1:0]  res_n;

	logic [CAP_W-1:0] cap_eff;
	logic [31:0]      line_count_inc;
	logic [7:0]       line_len;
	cmd_t             cmd;

	assign cfg_ready   = 1'b1;
	assign item_stall  = (rq_count_q > RQ_CNT_W'(RQ_DEPTH - 2));
	assign item_take   = item_valid && !item_stall;
	assign result_valid = (rq_count_q != '0);
	assign result_take = result_valid && !result_stall;

	assign cap_eff        = (cap_q > CAP_LIMIT) ? CAP_LIMIT : cap_q;
	assign line_count_inc = line_count_q + 32'd1;
	// held return is dropped when the line closes
	assign line_len       = byte_count_q - {7'd0, holding_cr_q};
	assign cmd            = cmd_t'(command);

	always_comb begin
		byte_count_d = byte_count_q;
		holding_cr_d = holding_cr_q;
		discarding_d = discarding_q;
		ended_d      = ended_q;
		line_count_d = line_count_q;
		res0         = '{kind: KIND_BYTE, out_byte: 8'd0, line_length: 8'd0,
			line_number: line_count_q, last_of_item: 1'b0};
		res1         = res0;
		res_n        = 2'd0;

		unique case (cmd)
			CMD_RESTART: begin
				byte_count_d = 8'd0;
				holding_cr_d = 1'b0;
				discarding_d = 1'b0;
				ended_d      = 1'b0;
				line_count_d = 32'd0;
			end
			CMD_END: begin
				if (!ended_q && !discarding_q && byte_count_q != 8'd0) begin
					line_count_d     = line_count_inc;
					res0.kind        = KIND_LINE;
					res0.line_length = line_len;
					res0.line_number = line_count_inc;
					res1.kind        = KIND_END;
					res1.line_number = line_count_inc;
					res_n            = 2'd2;
				end else begin
					res0.kind = KIND_END;
					res_n     = 2'd1;
				end
				byte_count_d = 8'd0;
				holding_cr_d = 1'b0;
				discarding_d = 1'b0;
				ended_d      = 1'b1;
			end
			CMD_DATA: begin
				priority if (ended_q) begin
					// bytes after end of input are ignored
				end else if (discarding_q) begin
					if (data_byte == CH_LF) begin
						line_count_d = line_count_inc;
						discarding_d = 1'b0;
					end
				end else if (cap_eff == '0) begin
					// zero capacity: every byte overflows at line start
					if (data_byte == CH_LF) begin
						line_count_d = line_count_inc;
					end else begin
						discarding_d = 1'b1;
					end
					if (holding_cr_q) begin
						res0.out_byte    = CH_CR;
						res1.kind        = KIND_OVFL;
						res1.line_length = byte_count_q;
						res1.line_number = line_count_d;
						res_n            = 2'd2;
					end else begin
						res0.kind        = KIND_OVFL;
						res0.line_length = byte_count_q;
						res0.line_number = line_count_d;
						res_n            = 2'd1;
					end
					byte_count_d = 8'd0;
					holding_cr_d = 1'b0;
				end else if (data_byte == CH_LF) begin
					line_count_d     = line_count_inc;
					res0.kind        = KIND_LINE;
					res0.line_length = line_len;
					res0.line_number = line_count_inc;
					res_n            = 2'd1;
					byte_count_d     = 8'd0;
					holding_cr_d     = 1'b0;
				end else if ({1'b0, byte_count_q} >= cap_eff - CAP_W'(1)) begin
					// line full: release held return, report, skip to LF
					if (holding_cr_q) begin
						res0.out_byte    = CH_CR;
						res1.kind        = KIND_OVFL;
						res1.line_length = byte_count_q;
						res_n            = 2'd2;
					end else begin
						res0.kind        = KIND_OVFL;
						res0.line_length = byte_count_q;
						res_n            = 2'd1;
					end
					byte_count_d = 8'd0;
					holding_cr_d = 1'b0;
					discarding_d = 1'b1;
				end else begin
					holding_cr_d = (data_byte == CH_CR);
					byte_count_d = byte_count_q + 8'd1;
					if (holding_cr_q) begin
						res0.out_byte = CH_CR;
						if (data_byte != CH_CR) begin
							res1.out_byte = data_byte;
							res_n         = 2'd2;
						end else begin
							res_n = 2'd1;
						end
					end else if (data_byte != CH_CR) begin
						res0.out_byte = data_byte;
						res_n         = 2'd1;
					end
				end
			end
			default: begin
				// unused command code: no effect
			end
		endcase

		res0.last_of_item = (res_n == 2'd1);
		res1.last_of_item = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			byte_count_q <= 8'd0;
			holding_cr_q <= 1'b0;
			discarding_q <= 1'b0;
			ended_q      <= 1'b0;
			line_count_q <= 32'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (item_take) begin
				byte_count_q <= byte_count_d;
				holding_cr_q <= holding_cr_d;
				discarding_q <= discarding_d;
				ended_q      <= ended_d;
				line_count_q <= line_count_d;
			end
		end
	end

	// Queue storage: payload only, no reset
	always_ff @(posedge clk) begin
		if (item_take && res_n != 2'd0) begin
			rq_q[wr_ptr_q] <= res0;
		end
		if (item_take && res_n == 2'd2) begin
			rq_q[wr_ptr_q + RQ_PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			rq_count_q <= '0;
		end else begin
			if (item_take) begin
				wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(res_n);
			end
			if (result_take) begin
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			end
			rq_count_q <= rq_count_q + (item_take ? RQ_CNT_W'(res_n) : '0)
				- RQ_CNT_W'(result_take);
		end
	end

	assign kind         = rq_q[rd_ptr_q].kind;
	assign out_byte     = rq_q[rd_ptr_q].out_byte;
	assign line_length  = rq_q[rd_ptr_q].line_length;
	assign line_number  = rq_q[rd_ptr_q].line_number;
	assign last_of_item = rq_q[rd_ptr_q].last_of_item;

	// Queue never overfills
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_count_q <= RQ_CNT_W'(RQ_DEPTH))
		else $error("result queue overflow");

	// After end of input the line state is empty
	a_ended_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> (byte_count_q == 8'd0 && !holding_cr_q && !discarding_q))
		else $error("line state not cleared after end of input");

	// A held return always counts in the line length
	a_cr_counted: assert property (@(posedge clk) disable iff (!arst_n)
		holding_cr_q |-> (byte_count_q != 8'd0 && !discarding_q))
		else $error("held carriage return not counted");

	// Restart clears counters
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && cmd == CMD_RESTART) |=> (line_count_q == 32'd0 && !ended_q))
		else $error("restart did not clear state");

endmodule
